// ===== rtl/atcu_pkg.sv =====
// ============================================================================
// atcu_pkg: shared types and constants of the text terminal cursor unit
// Screen geometry, control codes, queue entry and command formats.
// ============================================================================
package atcu_pkg;

    // Screen and cell geometry
    localparam logic [9:0] SCREEN_WIDTH  = 10'd240;
    localparam logic [8:0] SCREEN_HEIGHT = 9'd320;
    localparam logic [4:0] CHAR_WIDTH    = 5'd6;
    localparam logic [4:0] CHAR_HEIGHT   = 5'd9;
    localparam logic [15:0] PANEL_LINES  = 16'd320;

    // Width of the newline clear, clipped to the rect_w range
    localparam logic [7:0] NL_FILL_W = (SCREEN_WIDTH > 10'd255) ? 8'd255 : SCREEN_WIDTH[7:0];

    // Control bytes
    localparam logic [7:0] ESC_CODE     = 8'h1b;
    localparam logic [7:0] LF_CODE      = 8'h0a;
    localparam logic [7:0] CR_CODE      = 8'h0d;
    localparam logic [7:0] BS_CODE      = 8'h08;
    localparam logic [7:0] CSI_CODE     = 8'h5b;
    localparam logic [7:0] SEP_CODE     = 8'h3b;
    localparam logic [7:0] SGR_END_CODE = 8'h6d;
    localparam logic [7:0] DIGIT_0      = 8'h30;
    localparam logic [7:0] DIGIT_9      = 8'h39;

    // SGR parameter codes
    localparam logic [9:0] SGR_RESET  = 10'd0;
    localparam logic [9:0] SGR_BOLD   = 10'd1;
    localparam logic [9:0] SGR_FG_LO  = 10'd30;
    localparam logic [9:0] SGR_FG_HI  = 10'd37;
    localparam logic [9:0] SGR_BG_LO  = 10'd40;
    localparam logic [9:0] SGR_BG_HI  = 10'd47;
    localparam logic [9:0] PARAM_SAT  = 10'd999;

    // Colors
    localparam logic [15:0] FG_RESET = 16'hfd20;
    localparam logic [15:0] BLACK    = 16'h0000;
    localparam logic [15:0] WHITE    = 16'hffff;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCALE_X       = 2'd0;
    localparam logic [1:0] CFG_SCALE_Y       = 2'd1;
    localparam logic [1:0] CFG_WRAP_ENABLE   = 2'd2;
    localparam logic [1:0] CFG_SCROLL_ENABLE = 2'd3;

    typedef enum logic [1:0] {
        CMD_GLYPH  = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_SCROLL = 2'd2
    } cmd_kind_t;

    typedef enum logic [2:0] {
        OP_CHAR = 3'd0,
        OP_NL   = 3'd1,
        OP_CR   = 3'd2,
        OP_BS   = 3'd3,
        OP_ATTR = 3'd4
    } op_t;

    // One queued item for the back end
    typedef struct packed {
        op_t         op;
        logic [7:0]  code;
        logic [15:0] fg;
        logic [15:0] bg;
        logic        bold;
    } entry_t;

    // One display command
    typedef struct packed {
        cmd_kind_t   kind;
        logic [9:0]  x;
        logic [8:0]  y;
        logic [7:0]  w;
        logic [5:0]  h;
        logic [6:0]  glyph;
        logic [15:0] fg;
        logic [15:0] bg;
        logic        bold;
        logic [15:0] sstart;
        logic        last;
    } cmd_t;

    function automatic logic [2:0] clamp_scale(input logic [2:0] s);
        logic [2:0] r;
        if (s == 3'd0) begin
            r = 3'd1;
        end else if (s > 3'd4) begin
            r = 3'd4;
        end else begin
            r = s;
        end
        return r;
    endfunction

    function automatic logic [15:0] palette(input logic [2:0] i);
        logic [15:0] c;
        case (i)
            3'd0:    c = 16'h0000;
            3'd1:    c = 16'hf800;
            3'd2:    c = 16'h0780;
            3'd3:    c = 16'hfe00;
            3'd4:    c = 16'h001f;
            3'd5:    c = 16'hf81f;
            3'd6:    c = 16'h07ff;
            default: c = 16'hffff;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/atcu_queue.sv =====
// ============================================================================
// atcu_queue: small register FIFO
// Decouples the byte parser from the command sequencer.
// ============================================================================
module atcu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[head_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (do_pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[tail_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/atcu_front.sv =====
// ============================================================================
// atcu_front: byte parser
// Tracks escape state, collects SGR parameters, applies them one per cycle
// and queues text operations and attribute updates in order.
// ============================================================================
module atcu_front
    import atcu_pkg::*;
#(
    parameter int MAX_PARAMS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       push,
    output entry_t     push_entry,
    input  logic       q_full
);

    localparam int CNT_W = $clog2(MAX_PARAMS + 1);
    localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    typedef enum logic [1:0] {
        F_IDLE,
        F_APPLY,
        F_ATTR
    } fstate_t;

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_ESC,
        PH_CSI
    } phase_t;

    fstate_t          state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [9:0]       acc_reg, acc_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      fg_reg, fg_next;
    logic [15:0]      bg_reg, bg_next;
    logic             bold_reg, bold_next;
    logic [9:0]       param_q [MAX_PARAMS];

    logic             accept;
    logic             q_we;
    logic             room;
    logic [13:0]      acc_mul;
    logic [9:0]       pv;
    op_t              text_op;

    assign in_ready = (state_reg == F_IDLE) && !q_full;
    assign accept   = in_valid && in_ready;
    assign room     = (count_reg < CNT_W'(MAX_PARAMS));
    assign acc_mul  = 14'(acc_reg) * 14'd10 + 14'(rx_byte[3:0]);
    assign pv       = param_q[idx_reg];

    always_comb
    begin
        case (rx_byte)
            LF_CODE: text_op = OP_NL;
            CR_CODE: text_op = OP_CR;
            BS_CODE: text_op = OP_BS;
            default: text_op = OP_CHAR;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        idx_next   = idx_reg;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        bold_next  = bold_reg;
        q_we       = 1'b0;
        push       = 1'b0;
        push_entry = '{op: text_op, code: rx_byte, fg: BLACK, bg: BLACK, bold: 1'b0};

        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (rx_byte == ESC_CODE)
                    begin
                        phase_next = PH_ESC;
                    end else
                    begin
                        case (phase_reg)
                            PH_ESC:
                            begin
                                if (rx_byte == CSI_CODE)
                                begin
                                    phase_next = PH_CSI;
                                    count_next = '0;
                                    acc_next   = '0;
                                end else
                                begin
                                    phase_next = PH_TEXT;
                                end
                            end
                            PH_CSI:
                            begin
                                if (rx_byte >= DIGIT_0 && rx_byte <= DIGIT_9)
                                begin
                                    if (room)
                                    begin
                                        acc_next = (acc_mul > 14'(PARAM_SAT)) ? PARAM_SAT
                                                                              : acc_mul[9:0];
                                    end
                                end else if (rx_byte == SEP_CODE)
                                begin
                                    if (room)
                                    begin
                                        q_we       = 1'b1;
                                        count_next = count_reg + 1'b1;
                                        acc_next   = '0;
                                    end
                                end else if (rx_byte == SGR_END_CODE)
                                begin
                                    phase_next = PH_TEXT;
                                    idx_next   = '0;
                                    state_next = F_APPLY;
                                    if (room)
                                    begin
                                        q_we       = 1'b1;
                                        count_next = count_reg + 1'b1;
                                    end
                                end else
                                begin
                                    phase_next = PH_TEXT;
                                    count_next = '0;
                                    acc_next   = '0;
                                end
                            end
                            default:
                            begin
                                push = 1'b1;
                            end
                        endcase
                    end
                end
            end
            F_APPLY:
            begin
                if (pv == SGR_RESET)
                begin
                    if (count_reg == CNT_W'(1))
                    begin
                        fg_next = WHITE;
                        bg_next = BLACK;
                    end
                    bold_next = 1'b0;
                end else if (pv == SGR_BOLD)
                begin
                    bold_next = 1'b1;
                end else if (pv >= SGR_FG_LO && pv <= SGR_FG_HI)
                begin
                    fg_next = palette(3'(pv - SGR_FG_LO));
                end else if (pv >= SGR_BG_LO && pv <= SGR_BG_HI)
                begin
                    bg_next = palette(3'(pv - SGR_BG_LO));
                end
                idx_next = idx_reg + 1'b1;
                if (CNT_W'(idx_reg) == count_reg - 1'b1)
                begin
                    state_next = F_ATTR;
                end
            end
            F_ATTR:
            begin
                push_entry = '{op: OP_ATTR, code: 8'd0, fg: fg_reg, bg: bg_reg, bold: bold_reg};
                if (!q_full)
                begin
                    push       = 1'b1;
                    count_next = '0;
                    acc_next   = '0;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            phase_reg <= PH_TEXT;
            count_reg <= '0;
            acc_reg   <= '0;
            idx_reg   <= '0;
            fg_reg    <= FG_RESET;
            bg_reg    <= BLACK;
            bold_reg  <= 1'b0;
        end else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            idx_reg   <= idx_next;
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
            bold_reg  <= bold_next;
        end
    end

    // parameter slots, each written at the current count before the count steps
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            param_q[count_reg[IDX_W-1:0]] <= acc_reg;
        end
    end

endmodule

// ===== rtl/atcu_back.sv =====
// ============================================================================
// atcu_back: command sequencer
// Owns cursor, attributes and configuration; turns queued operations into
// glyph, fill and scroll commands through a registered output stage.
// ============================================================================
module atcu_back
    import atcu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [2:0] cfg_data,
    input  logic       q_empty,
    input  entry_t     q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output cmd_t       out_cmd
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_NL_FILL,
        B_SCROLL
    } bstate_t;

    bstate_t     state_reg, state_next;
    logic [2:0]  scale_x_reg, scale_y_reg;
    logic        wrap_reg, scroll_en_reg;
    logic [9:0]  cur_x_reg, cur_x_next;
    logic [8:0]  cur_y_reg, cur_y_next;
    logic [15:0] fg_reg, fg_next;
    logic [15:0] bg_reg, bg_next;
    logic        bold_reg, bold_next;
    logic        out_valid_reg, out_valid_next;
    cmd_t        cmd_reg, cmd_next;

    logic        out_free;
    logic        load;
    logic [6:0]  cw, ch;
    logic [5:0]  ch_sat;
    logic [10:0] x_sum;
    logic [9:0]  nx;
    logic [9:0]  bs_x;
    logic [9:0]  y_sum;
    logic [10:0] y_chk;
    logic [8:0]  ny;
    logic        glyph_ok;
    logic        nl_follow;

    assign cw       = 7'(CHAR_WIDTH) * 7'(clamp_scale(scale_x_reg));
    assign ch       = 7'(CHAR_HEIGHT) * 7'(clamp_scale(scale_y_reg));
    assign ch_sat   = (ch > 7'd63) ? 6'd63 : ch[5:0];
    assign x_sum    = 11'(cur_x_reg) + 11'(cw);
    assign nx       = x_sum[10] ? 10'd1023 : x_sum[9:0];
    assign bs_x     = (cur_x_reg > 10'(cw)) ? cur_x_reg - 10'(cw) : 10'd0;
    assign y_sum    = 10'(cur_y_reg) + 10'(ch);
    assign y_chk    = 11'(y_sum) + 11'(CHAR_HEIGHT);
    assign ny       = (y_chk > 11'(SCREEN_HEIGHT)) ? 9'd0 : y_sum[8:0];
    assign glyph_ok = (cur_x_reg < SCREEN_WIDTH) && (cur_y_reg < SCREEN_HEIGHT)
                      && !q_head.code[7];
    assign nl_follow = (nx >= SCREEN_WIDTH) && wrap_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == B_IDLE) && !q_empty && out_free;
    assign out_valid = out_valid_reg;
    assign out_cmd   = cmd_reg;

    always_comb
    begin
        state_next = state_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        bold_next  = bold_reg;
        load       = 1'b0;
        cmd_next   = '0;

        case (state_reg)
            B_IDLE:
            begin
                if (q_pop)
                begin
                    case (q_head.op)
                        OP_ATTR:
                        begin
                            fg_next   = q_head.fg;
                            bg_next   = q_head.bg;
                            bold_next = q_head.bold;
                        end
                        OP_CR:
                        begin
                            cur_x_next = '0;
                        end
                        OP_NL:
                        begin
                            state_next = B_NL_FILL;
                        end
                        OP_BS:
                        begin
                            cur_x_next    = bs_x;
                            load          = 1'b1;
                            cmd_next.kind = CMD_FILL;
                            cmd_next.x    = bs_x;
                            cmd_next.y    = cur_y_reg;
                            cmd_next.w    = 8'(cw);
                            cmd_next.h    = ch_sat;
                            cmd_next.last = 1'b1;
                        end
                        default:
                        begin
                            cur_x_next = nx;
                            if (glyph_ok)
                            begin
                                load           = 1'b1;
                                cmd_next.kind  = CMD_GLYPH;
                                cmd_next.x     = cur_x_reg;
                                cmd_next.y     = cur_y_reg;
                                cmd_next.glyph = q_head.code[6:0];
                                cmd_next.fg    = fg_reg;
                                cmd_next.bg    = bg_reg;
                                cmd_next.bold  = bold_reg;
                                cmd_next.last  = !nl_follow;
                            end
                            if (nl_follow)
                            begin
                                state_next = B_NL_FILL;
                            end
                        end
                    endcase
                end
            end
            B_NL_FILL:
            begin
                if (out_free)
                begin
                    cur_x_next    = '0;
                    cur_y_next    = ny;
                    load          = 1'b1;
                    cmd_next.kind = CMD_FILL;
                    cmd_next.y    = ny;
                    cmd_next.w    = NL_FILL_W;
                    cmd_next.h    = ch_sat;
                    state_next    = B_SCROLL;
                end
            end
            B_SCROLL:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    cmd_next.kind   = CMD_SCROLL;
                    cmd_next.sstart = scroll_en_reg
                                      ? PANEL_LINES - 16'(cur_y_reg) - 16'(ch) : 16'd0;
                    cmd_next.last   = 1'b1;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            scale_x_reg   <= 3'd1;
            scale_y_reg   <= 3'd1;
            wrap_reg      <= 1'b1;
            scroll_en_reg <= 1'b1;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            fg_reg        <= FG_RESET;
            bg_reg        <= BLACK;
            bold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
        end else
        begin
            state_reg     <= state_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            bold_reg      <= bold_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                cmd_reg <= cmd_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCALE_X:       scale_x_reg   <= cfg_data;
                    CFG_SCALE_Y:       scale_y_reg   <= cfg_data;
                    CFG_WRAP_ENABLE:   wrap_reg      <= cfg_data[0];
                    CFG_SCROLL_ENABLE: scroll_en_reg <= cfg_data[0];
                    default:           scale_x_reg   <= scale_x_reg;
                endcase
            end
        end
    end

endmodule

// ===== rtl/ansi_text_terminal_cursor_unit.sv =====
// ============================================================================
// ansi_text_terminal_cursor_unit: text terminal with SGR escape parser
// Flow: a text byte is queued on its accept cycle; its first command is then
//   loaded from the queue head into the output register, via B_NL_FILL when it
//   opens with the newline clear. Commands leave one per cycle while out_ready
//   is high. Throughput: one byte per cycle while the parser is idle and the
//   queue has room; newlines pass B_NL_FILL, B_SCROLL; SGR ends F_APPLY, F_ATTR.
// Reset: rst_n clears cursor, attributes, parser, queue and configuration.
// ============================================================================
module ansi_text_terminal_cursor_unit
    import atcu_pkg::*;
#(
    parameter int MAX_PARAMS  = 10,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    // command output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  cmd_kind,
    output logic [9:0]  pos_x,
    output logic [8:0]  pos_y,
    output logic [7:0]  rect_w,
    output logic [5:0]  rect_h,
    output logic [6:0]  glyph_code,
    output logic [15:0] fg_color,
    output logic [15:0] bg_color,
    output logic        bold_flag,
    output logic [15:0] scroll_start,
    output logic        last_of_run
);

    localparam int ENTRY_W = $bits(entry_t);

    logic               push;
    entry_t             push_entry;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_rdata;
    entry_t             q_head;
    cmd_t               cmd;

    // Configuration is always taken; the user must write it only while the unit is idle; not enforced by the block.
    assign cfg_ready = 1'b1;

    // Front end: escape parsing and SGR application. Everything that touches
    // the cursor or the drawing attributes goes through the queue in byte order,
    // so attribute changes land between the right glyphs.
    atcu_front #(
        .MAX_PARAMS(MAX_PARAMS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .push      (push),
        .push_entry(push_entry),
        .q_full    (q_full)
    );

    atcu_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_entry),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (q_rdata),
        .empty    (q_empty)
    );

    assign q_head = entry_t'(q_rdata);

    // Back end: cursor tracking and command generation. A newline is a fill
    // of the new line followed by a scroll update; last_of_run marks the final
    // command of each byte.
    atcu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_cmd  (cmd)
    );

    // Unused fields of each command kind are zero in the output register.
    assign cmd_kind     = cmd.kind;
    assign pos_x        = cmd.x;
    assign pos_y        = cmd.y;
    assign rect_w       = cmd.w;
    assign rect_h       = cmd.h;
    assign glyph_code   = cmd.glyph;
    assign fg_color     = cmd.fg;
    assign bg_color     = cmd.bg;
    assign bold_flag    = cmd.bold;
    assign scroll_start = cmd.sstart;
    assign last_of_run  = cmd.last;

endmodule
